// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the substring search block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define DBCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds through reset
`define DBCS_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dbcs_pkg.sv =====
// Package for the double-byte aware substring search: register codes, widths
// and the structs passed between the top level and the window cells.
// No dependencies.
`default_nettype none

package dbcs_pkg;

   // configuration port
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 64;
   localparam int REG_IDX_W = 2;

   // register indexes (paddr[4:3])
   localparam logic [REG_IDX_W-1:0] REG_LEAD_RANGES    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int POS_OUT_W = 16;
   localparam int PLEN_W    = 4;
   localparam int PAT_REG_BYTES = 8;   // bytes held by the pattern register
   localparam int RANGE_REG_PAIRS = 4; // low/high pairs held by the range register

   typedef logic [BYTE_W-1:0] byte_type;

   // per-cycle control from the top level to every cell
   typedef struct packed {
      logic shift;   // take neighbour's byte and candidate bit
      logic clear;   // drop all start candidates (end of string)
   } cell_ctrl_type;

   // static compare setup for one cell, derived from the pattern registers
   typedef struct packed {
      byte_type pat_byte;  // pattern byte this cell must hold for a match
      logic     used;      // cell lies inside the pattern
      logic     tap;       // cell holds the oldest byte of the pattern window
   } cell_cfg_type;

   // compare status returned by one cell
   typedef struct packed {
      logic ok;    // byte matches, or cell not in use
      logic hit;   // tap cell with a valid start candidate
   } cell_stat_type;

endpackage

`default_nettype wire

// ===== src/dbcs_cell.sv =====
// One cell of the search window: a string byte and its start-candidate bit,
// shifted on to the next cell, plus the local byte compare. Uses dbcs_pkg.
`default_nettype none

module dbcs_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  dbcs_pkg::cell_ctrl_type ctrl,
   input  dbcs_pkg::cell_cfg_type  cfg,
   input  dbcs_pkg::byte_type      byte_in,
   input  wire                     cand_in,
   input  wire                     cand_force,
   output dbcs_pkg::byte_type      byte_out,
   output logic                    cand_out,
   output dbcs_pkg::cell_stat_type stat
);
   import dbcs_pkg::*;

   byte_type byte_ff;
   logic     cand_ff;

   // window byte: payload, no reset needed
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         byte_ff <= byte_in;
      end
   end

   // candidate bit
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         cand_ff <= 1'b0;
      end else if (ctrl.shift) begin
         cand_ff <= cand_in;
      end
   end

   assign byte_out = byte_ff;
   assign cand_out = cand_ff;

   // local compare; cand_force settles a lead byte seen just before the terminator
   assign stat.ok  = !cfg.used || (byte_ff == cfg.pat_byte);
   assign stat.hit = cfg.tap && (cand_ff || cand_force);

endmodule

`default_nettype wire

// ===== src/dbcs_lead_detect.sv =====
// Lead-byte classifier: checks a byte against the configured inclusive ranges,
// the list ending at the first all-zero pair. Uses dbcs_pkg.
`default_nettype none

module dbcs_lead_detect #(
   parameter int N_RANGES = 4
) (
   input  wire [dbcs_pkg::CSR_DW-1:0] lead_ranges,
   input  dbcs_pkg::byte_type         data_byte,
   output logic                       is_lead
);
   import dbcs_pkg::*;

   localparam int RANGES_USED = (N_RANGES < RANGE_REG_PAIRS) ? N_RANGES : RANGE_REG_PAIRS;

   always_comb begin
      logic     ended;
      byte_type lo;
      byte_type hi;
      ended   = 1'b0;
      is_lead = 1'b0;
      for (int r = 0; r < RANGES_USED; r++) begin
         lo = lead_ranges[16*r +: 8];
         hi = lead_ranges[16*r+8 +: 8];
         if (!ended) begin
            if (lo == '0 && hi == '0) begin
               ended = 1'b1;
            end else if (data_byte >= lo && data_byte <= hi) begin
               is_lead = 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/dbcs_aware_substring_search.sv =====
// Top level of the double-byte aware substring search: configuration registers,
// scan control, the chain of window cells and the result register.
// Depends on dbcs_pkg, dbcs_cell and dbcs_lead_detect.
//
// Usage:
//  - Configure lead_ranges, pattern_bytes and pattern_length over the APB port
//    (byte addresses 0, 8, 16; 64-bit data) while no string is in flight.
//  - Stream a NUL-terminated string on req_data_byte, one transfer per byte
//    (req_valid high, req_stall low). A byte is taken every unstalled cycle.
//  - Each terminator yields one transfer on rsp_*: found, match_position and
//    too_long. It appears in the cycle after the terminator is taken; other
//    bytes give no result.
//  - Throughput is one byte per unstalled cycle: each byte shifts the window
//    cells one place and all cells compare in parallel in the same cycle.
//  - While a result is held by rsp_stall, further non-NUL bytes are still
//    taken; a new terminator is stalled until the held result leaves.
//  - Synchronous reset clears the scan state, the registers and the result
//    valid flag; the block can take a byte as soon as reset is released.
//  - Bytes at offset MAX_STRING_LEN or beyond are dropped and flag too_long.
`default_nettype none

module dbcs_aware_substring_search #(
   parameter int MAX_PATTERN    = 8,
   parameter int MAX_RANGES     = 4,
   parameter int MAX_STRING_LEN = 65536
) (
   input  wire                          clock,
   input  wire                          reset,
   // string input
   input  wire                          req_valid,
   output logic                         req_stall,
   input  dbcs_pkg::byte_type           req_data_byte,
   // result output
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_found,
   output logic [dbcs_pkg::POS_OUT_W-1:0] rsp_match_position,
   output logic                         rsp_too_long,
   // configuration
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [dbcs_pkg::CSR_AW-1:0]  paddr,
   input  wire  [dbcs_pkg::CSR_DW-1:0]  pwdata,
   output logic [dbcs_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import dbcs_pkg::*;

   localparam int POS_W   = $clog2(MAX_STRING_LEN + 1);
   localparam int PAT_USE = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
   localparam logic [POS_W-1:0]  POS_LIMIT   = POS_W'(MAX_STRING_LEN);
   localparam logic [PLEN_W-1:0] PAT_USE_LEN = PLEN_W'(PAT_USE);

   // configuration registers
   logic [CSR_DW-1:0] lead_ranges_ff;
   logic [CSR_DW-1:0] pattern_bytes_ff;
   logic [PLEN_W-1:0] pattern_length_ff;

   // scan state
   logic [POS_W-1:0]     pos_ff,   pos_in;
   logic                 lead_ff,  lead_in;
   logic                 match_ff, match_in;
   logic [POS_OUT_W-1:0] lpos_ff,  lpos_in;
   logic                 ovf_ff,   ovf_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff,     found_in;
   logic [POS_OUT_W-1:0] mpos_ff,      mpos_in;
   logic                 too_long_ff,  too_long_in;

   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_write;
   logic                 accept;
   logic                 is_nul;
   logic                 ovf_path;
   logic                 is_lead;
   logic                 cand_now;
   logic                 test_pass;
   logic                 hit_any;
   logic                 all_ok;
   logic [PLEN_W-1:0]    eff_len;
   logic [POS_OUT_W-1:0] start_pos;

   cell_ctrl_type              ctrl;
   cell_cfg_type               cell_cfg  [MAX_PATTERN];
   cell_stat_type              cell_stat [MAX_PATTERN];
   byte_type                   byte_chain[MAX_PATTERN];
   logic [MAX_PATTERN-1:0]     cand_chain;

   // ---------------------------------------------------------------
   // configuration port
   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_AW-1 -: REG_IDX_W];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ranges_ff    <= '0;
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_LEAD_RANGES:    lead_ranges_ff    <= pwdata;
            REG_PATTERN_BYTES:  pattern_bytes_ff  <= pwdata;
            REG_PATTERN_LENGTH: pattern_length_ff <= pwdata[PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LEAD_RANGES:    prdata = lead_ranges_ff;
         REG_PATTERN_BYTES:  prdata = pattern_bytes_ff;
         REG_PATTERN_LENGTH: prdata = CSR_DW'(pattern_length_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // effective pattern length: capped, and cut at the first zero byte
   always_comb begin
      logic [PLEN_W-1:0] cap;
      logic              zero_seen;
      cap       = (pattern_length_ff > PAT_USE_LEN) ? PAT_USE_LEN : pattern_length_ff;
      eff_len   = cap;
      zero_seen = 1'b0;
      for (int k = 0; k < PAT_USE; k++) begin
         if (!zero_seen && PLEN_W'(k) < cap && pattern_bytes_ff[8*k +: 8] == '0) begin
            eff_len   = PLEN_W'(k);
            zero_seen = 1'b1;
         end
      end
   end

   // per-cell compare setup: cell j holds pattern byte eff_len-1-j
   always_comb begin
      logic [PLEN_W:0] diff;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         diff                 = {1'b0, eff_len} - (PLEN_W+1)'(j + 1);
         cell_cfg[j].used     = (PLEN_W+1)'(j) < {1'b0, eff_len};
         cell_cfg[j].tap      = (eff_len != '0) && (diff == '0);
         cell_cfg[j].pat_byte = pattern_bytes_ff[8*diff[2:0] +: 8];
      end
   end

   // ---------------------------------------------------------------
   // input handshake: only a terminator waits for a held result
   assign req_stall = rsp_valid_ff && rsp_stall && (req_data_byte == '0);
   assign accept    = req_valid && !req_stall;
   assign is_nul    = (req_data_byte == '0);
   assign ovf_path  = !is_nul && (ovf_ff || pos_ff >= POS_LIMIT);

   dbcs_lead_detect #(
      .N_RANGES (MAX_RANGES)
   ) u_lead (
      .lead_ranges (lead_ranges_ff),
      .data_byte   (req_data_byte),
      .is_lead     (is_lead)
   );

   // second byte of a pair, or a lead byte, cannot start a match
   assign cand_now = !lead_ff && !is_lead;

   assign ctrl.shift = accept && !is_nul && !ovf_path;
   assign ctrl.clear = accept && is_nul;

   // ---------------------------------------------------------------
   // window cells
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j == 0) begin : g_head
         dbcs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cfg        (cell_cfg[j]),
            .byte_in    (req_data_byte),
            .cand_in    (cand_now),
            .cand_force (lead_ff && is_nul),
            .byte_out   (byte_chain[j]),
            .cand_out   (cand_chain[j]),
            .stat       (cell_stat[j])
         );
      end else begin : g_body
         dbcs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cfg        (cell_cfg[j]),
            .byte_in    (byte_chain[j-1]),
            .cand_in    (cand_chain[j-1]),
            .cand_force (1'b0),
            .byte_out   (byte_chain[j]),
            .cand_out   (cand_chain[j]),
            .stat       (cell_stat[j])
         );
      end
   end

   // combine cell results
   always_comb begin
      hit_any = 1'b0;
      all_ok  = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         hit_any = hit_any | cell_stat[j].hit;
         all_ok  = all_ok & cell_stat[j].ok;
      end
   end

   assign test_pass = !ovf_ff && (eff_len != '0) && !match_ff && hit_any && all_ok;
   assign start_pos = POS_OUT_W'(pos_ff) - POS_OUT_W'(eff_len);

   // ---------------------------------------------------------------
   // scan and result next state
   always_comb begin
      pos_in       = pos_ff;
      lead_in      = lead_ff;
      match_in     = match_ff;
      lpos_in      = lpos_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      mpos_in      = mpos_ff;
      too_long_in  = too_long_ff;
      if (accept) begin
         if (ovf_path) begin
            ovf_in = 1'b1;
         end else if (is_nul) begin
            // terminator: report and start over
            rsp_valid_in = 1'b1;
            too_long_in  = ovf_ff;
            if (eff_len == '0) begin
               found_in = 1'b1;
               mpos_in  = '0;
            end else if (test_pass) begin
               found_in = 1'b1;
               mpos_in  = start_pos;
            end else begin
               found_in = match_ff;
               mpos_in  = match_ff ? lpos_ff : '0;
            end
            pos_in   = '0;
            lead_in  = 1'b0;
            match_in = 1'b0;
            lpos_in  = '0;
            ovf_in   = 1'b0;
         end else begin
            if (test_pass) begin
               match_in = 1'b1;
               lpos_in  = start_pos;
            end
            lead_in = !lead_ff && is_lead;
            pos_in  = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         lead_ff      <= 1'b0;
         match_ff     <= 1'b0;
         lpos_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         lead_ff      <= lead_in;
         match_ff     <= match_in;
         lpos_ff      <= lpos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      mpos_ff     <= mpos_in;
      too_long_ff <= too_long_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_match_position = mpos_ff;
   assign rsp_too_long       = too_long_ff;

endmodule

`default_nettype wire

// ===== src/dbcs_checker.sv =====
// Port-level checker for dbcs_aware_substring_search, bound to the top level.
// Depends on dbcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbcs_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire [dbcs_pkg::BYTE_W-1:0]   req_data_byte,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire                          rsp_found,
   input wire [dbcs_pkg::POS_OUT_W-1:0] rsp_match_position,
   input wire                          rsp_too_long
);
   import dbcs_pkg::*;

   // a held result keeps its payload
   `DBCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_position) && $stable(rsp_too_long), "result changed while stalled")

   // nothing comes out straight after reset
   `DBCS_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // a fresh result follows a terminator transfer
   `DBCS_ASSERT(a_rsp_after_nul, clock, reset, rsp_valid && !$past(rsp_valid) |-> $past(req_valid && !req_stall && req_data_byte == '0), "result without terminator")

   // no match reports position zero
   `DBCS_ASSERT(a_pos_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_match_position == '0, "position set without match")

   // input is only held back by a stalled result
   `DBCS_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without cause")

endmodule

bind dbcs_aware_substring_search dbcs_checker u_dbcs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_data_byte      (req_data_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_found          (rsp_found),
   .rsp_match_position (rsp_match_position),
   .rsp_too_long       (rsp_too_long)
);

`default_nettype wire
